FILE: design/bsm_pkg.sv
// ----------------------------------------------------------------------------
// bsm_pkg
// Shared types, register addresses and helpers for the bank switch mapper.
// ----------------------------------------------------------------------------
`default_nettype none

package bsm_pkg;

    localparam int NUM_PRG_BANKS = 32;

    localparam logic [7:0] PRG_MASK    = 8'(NUM_PRG_BANKS - 1);
    localparam logic [7:0] PRG_DEFAULT = 8'(NUM_PRG_BANKS - 2);

    // Request kinds.
    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_TICK  = 1'b1;

    // Register pages (address bits 15..12).
    localparam logic [3:0] PAGE_PRG       = 4'h8;
    localparam logic [3:0] PAGE_PRG_THIRD = 4'h9;
    localparam logic [3:0] PAGE_CHR_FIRST = 4'hA;
    localparam logic [3:0] PAGE_CHR_LAST  = 4'hD;
    localparam logic [3:0] PAGE_RELOAD    = 4'hE;

    // Exact control addresses.
    localparam logic [15:0] ADDR_IRQ_LOAD = 16'hF000;
    localparam logic [15:0] ADDR_IRQ_CTRL = 16'hF001;
    localparam logic [15:0] ADDR_MIRROR   = 16'hF002;

    typedef struct packed {
        logic        kind;
        logic [15:0] address;
        logic [7:0]  write_data;
    } request_t;

    typedef struct packed {
        logic [2:0][7:0] prg_select;
        logic            prg_third_written;
        logic [7:0][7:0] chr_select;
        logic [15:0]     reload_value;
        logic [15:0]     down_counter;
        logic            count_enable;
        logic [2:0]      width_code;
        logic [1:0]      mirror_select;
        logic            irq_pending;
    } mapper_state_t;

    function automatic logic [7:0] set_nibble(logic [7:0] old, logic high, logic [3:0] nib);
        logic [7:0] res;
        res = high ? {nib, old[3:0]} : {old[7:4], nib};
        return res;
    endfunction

    function automatic logic [15:0] width_mask(logic [2:0] code);
        logic [15:0] m;
        case (code) inside
            3'd0:         m = 16'hFFFF;
            3'd1:         m = 16'h0FFF;
            [3'd2:3'd3]:  m = 16'h00FF;
            default:      m = 16'h000F;
        endcase
        return m;
    endfunction

endpackage

`default_nettype wire

FILE: design/bsm_regs.sv
// ----------------------------------------------------------------------------
// bsm_regs
// Mapper register file and IRQ down counter, updated once per request.
// ----------------------------------------------------------------------------
`default_nettype none

module bsm_regs (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               update,
    input  wire bsm_pkg::request_t  req,
    output bsm_pkg::mapper_state_t  state_next
);

    bsm_pkg::mapper_state_t state_reg;

    logic [3:0]  page;
    logic [11:0] low;
    logic [3:0]  nib;
    logic [15:0] mask;
    logic [15:0] dec;
    logic [15:0] counter_new;
    logic [2:0]  chr_idx;
    logic [3:0]  chr_page;

    always_comb
    begin
        page        = req.address[15:12];
        low         = req.address[11:0];
        nib         = req.write_data[3:0];
        mask        = bsm_pkg::width_mask(state_reg.width_code);
        dec         = (state_reg.down_counter & mask) - 16'd1;
        counter_new = (state_reg.down_counter & ~mask) | (dec & mask);
        chr_page    = page - bsm_pkg::PAGE_CHR_FIRST;
        chr_idx     = {chr_page[1:0], low[1]};

        state_next = state_reg;
        if (req.kind == bsm_pkg::KIND_TICK)
        begin
            if (state_reg.count_enable)
            begin
                state_next.down_counter = counter_new;
                // Only the selected low bits wrapping to all ones raise the IRQ.
                if ((counter_new & mask) == mask)
                    state_next.irq_pending = 1'b1;
            end
        end
        else if (page == bsm_pkg::PAGE_PRG && low <= 12'd3)
        begin
            state_next.prg_select[low[1]] =
                bsm_pkg::set_nibble(state_reg.prg_select[low[1]], low[0], nib);
        end
        else if (page == bsm_pkg::PAGE_PRG_THIRD && low <= 12'd1)
        begin
            state_next.prg_select[2] =
                bsm_pkg::set_nibble(state_reg.prg_select[2], low[0], nib);
            state_next.prg_third_written = 1'b1;
        end
        else if (page >= bsm_pkg::PAGE_CHR_FIRST && page <= bsm_pkg::PAGE_CHR_LAST
                 && low <= 12'd3)
        begin
            state_next.chr_select[chr_idx] =
                bsm_pkg::set_nibble(state_reg.chr_select[chr_idx], low[0], nib);
        end
        else if (page == bsm_pkg::PAGE_RELOAD && low <= 12'd3)
        begin
            state_next.reload_value[{low[1:0], 2'b00} +: 4] = nib;
        end
        else if (req.address == bsm_pkg::ADDR_IRQ_LOAD)
        begin
            state_next.down_counter = state_reg.reload_value;
            state_next.irq_pending  = 1'b0;
        end
        else if (req.address == bsm_pkg::ADDR_IRQ_CTRL)
        begin
            state_next.count_enable = req.write_data[0];
            state_next.width_code   = req.write_data[3:1];
            state_next.irq_pending  = 1'b0;
        end
        else if (req.address == bsm_pkg::ADDR_MIRROR)
        begin
            state_next.mirror_select = req.write_data[1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= '0;
        else if (update)
            state_reg <= state_next;
    end

endmodule

`default_nettype wire

FILE: design/bank_switch_mapper_with_irq_timer_unit.sv
// ----------------------------------------------------------------------------
// bank_switch_mapper_with_irq_timer_unit
// A request waits in the request register until the result register is free
// or drains. Throughput: one request per cycle unless out_stall holds it; the
// two registers each hold one item, and the mapper state updates in one step.
// Reset (asynchronous, active low) clears all mapper state and both valids.
// ----------------------------------------------------------------------------
`default_nettype none

module bank_switch_mapper_with_irq_timer_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        kind,
    input  wire logic [15:0] address,
    input  wire logic [7:0]  write_data,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic             irq_line,
    output logic [7:0]       prg_window0_bank,
    output logic [7:0]       prg_window1_bank,
    output logic [7:0]       prg_window2_bank,
    output logic [63:0]      chr_banks_packed,
    output logic [1:0]       mirroring_mode,
    output logic [15:0]      irq_count_value
);

    logic                   req_valid_reg;
    bsm_pkg::request_t      req_reg;
    logic                   out_valid_reg;
    logic                   advance;
    bsm_pkg::mapper_state_t state_next;

    logic        irq_reg;
    logic [7:0]  prg0_reg;
    logic [7:0]  prg1_reg;
    logic [7:0]  prg2_reg;
    logic [63:0] chr_reg;
    logic [1:0]  mirror_reg;
    logic [15:0] count_reg;

    // The held request moves on whenever the result register is free or drains.
    assign advance  = req_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = req_valid_reg && !advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (!in_stall)
                req_valid_reg <= in_valid;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall)
        begin
            req_reg.kind       <= kind;
            req_reg.address    <= address;
            req_reg.write_data <= write_data;
        end
    end

    bsm_regs u_regs (
        .clk        (clk),
        .rst_n      (rst_n),
        .update     (advance),
        .req        (req_reg),
        .state_next (state_next)
    );

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            irq_reg    <= state_next.irq_pending;
            prg0_reg   <= state_next.prg_select[0] & bsm_pkg::PRG_MASK;
            prg1_reg   <= state_next.prg_select[1] & bsm_pkg::PRG_MASK;
            prg2_reg   <= state_next.prg_third_written
                          ? (state_next.prg_select[2] & bsm_pkg::PRG_MASK)
                          : bsm_pkg::PRG_DEFAULT;
            chr_reg    <= state_next.chr_select;
            mirror_reg <= state_next.mirror_select;
            count_reg  <= state_next.down_counter;
        end
    end

    assign out_valid        = out_valid_reg;
    assign irq_line         = irq_reg;
    assign prg_window0_bank = prg0_reg;
    assign prg_window1_bank = prg1_reg;
    assign prg_window2_bank = prg2_reg;
    assign chr_banks_packed = chr_reg;
    assign mirroring_mode   = mirror_reg;
    assign irq_count_value  = count_reg;

endmodule

`default_nettype wire
